// File: hdl/lds_pkg.sv
// Shared types and constants for the Lambertian diffuse shade unit.
// No dependencies; imported by lambert_diffuse_shade_unit and its testbench.
package lds_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIGHT_X     = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y     = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z     = 3'd2;
  localparam logic [2:0] REG_INTENSITY_R = 3'd3;
  localparam logic [2:0] REG_INTENSITY_G = 3'd4;
  localparam logic [2:0] REG_INTENSITY_B = 3'd5;

  localparam int CFG_IDX_W = 3;
  localparam int COS_BITS  = 17;           // cosine in Q1.16, 0..65536
  localparam int X_W       = 100;          // c^2 * P
  localparam int Y_W       = 84;           // c * P
  localparam int P_W       = 66;           // |n|^2 * |d|^2
  localparam int R_W       = 98;           // dot^2 * 2^32
  localparam int T_W       = 104;          // trial sum width
  localparam logic [16:0] COS_ONE = 17'd65536;

  // One stage of the cosine search pipeline.
  typedef struct packed {
    logic                vld;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
    logic [COS_BITS-1:0] c;
    logic [P_W-1:0]      p;
    logic [R_W-1:0]      r;
    logic                dg;
    logic [15:0]         rr;
    logic [15:0]         rg;
    logic [15:0]         rb;
  } lds_cos_t;

endpackage

// File: hdl/lambert_diffuse_shade_unit.sv
// Lambertian diffuse shade unit: top level with the full shading pipeline.
// Depends on lds_pkg for register indexes, widths and the cosine stage type.
//
// The unit shades one surface point against one point light per transfer. The light
// position and the three channel intensities are written through the configuration
// port, which is always ready; write it only while the pipeline is empty. An item can
// enter in every cycle unless stalled, and passes through one input register, products,
// sums, partial products of the two wide squares, their sums, seventeen cosine bit
// stages, the reflectance times intensity product and the output register.
// The seventeen-stage cosine search sets the latency: each stage decides one bit of
// floor(65536 * cos) with one wide add and compare. The whole pipeline stalls together
// when the output holds a result that is not taken, so in_stall follows out_stall.
// A zero normal or a point sitting on the light gives zero shades with degenerate set;
// a surface facing away from the light gives zero shades with degenerate clear.
module lambert_diffuse_shade_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_point_x,
  input  logic signed [15:0]           in_point_y,
  input  logic signed [15:0]           in_point_z,
  input  logic signed [15:0]           in_normal_x,
  input  logic signed [15:0]           in_normal_y,
  input  logic signed [15:0]           in_normal_z,
  input  logic [15:0]                  in_refl_r,
  input  logic [15:0]                  in_refl_g,
  input  logic [15:0]                  in_refl_b,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_shade_r,
  output logic [15:0]                  out_shade_g,
  output logic [15:0]                  out_shade_b,
  output logic                         out_degenerate
);
  import lds_pkg::*;

  localparam int NSTG = COS_BITS;

  // Configuration registers.
  logic signed [15:0] light_r [3];
  logic [15:0]        inten_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= 16'sd0;
      light_r[1] <= 16'sd0;
      light_r[2] <= 16'sd0;
      inten_r[0] <= 16'd256;
      inten_r[1] <= 16'd256;
      inten_r[2] <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIGHT_X:     light_r[0] <= $signed(cfg_data);
        REG_LIGHT_Y:     light_r[1] <= $signed(cfg_data);
        REG_LIGHT_Z:     light_r[2] <= $signed(cfg_data);
        REG_INTENSITY_R: inten_r[0] <= cfg_data;
        REG_INTENSITY_G: inten_r[1] <= cfg_data;
        REG_INTENSITY_B: inten_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output holds an untaken result.
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: light direction and registered inputs.
  logic               v1_r;
  logic signed [16:0] d1_r [3];
  logic signed [15:0] n1_r [3];
  logic [15:0]        refl1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r[0]    <= 17'(light_r[0]) - 17'(in_point_x);
      d1_r[1]    <= 17'(light_r[1]) - 17'(in_point_y);
      d1_r[2]    <= 17'(light_r[2]) - 17'(in_point_z);
      n1_r[0]    <= in_normal_x;
      n1_r[1]    <= in_normal_y;
      n1_r[2]    <= in_normal_z;
      refl1_r[0] <= in_refl_r;
      refl1_r[1] <= in_refl_g;
      refl1_r[2] <= in_refl_b;
    end
  end

  // Stage 2: per-axis products.
  logic               v2_r;
  logic signed [32:0] nd2_r [3];
  logic [30:0]        nn2_r [3];
  logic [31:0]        dd2_r [3];
  logic [15:0]        refl2_r [3];
  logic signed [32:0] nd_nxt [3];
  logic signed [31:0] nn_full [3];
  logic signed [32:0] dd_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_nxt[i]  = $signed(33'(n1_r[i])) * $signed(33'(d1_r[i]));
      nn_full[i] = $signed(32'(n1_r[i])) * $signed(32'(n1_r[i]));
      dd_full[i] = $signed(33'(d1_r[i])) * $signed(33'(d1_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nd2_r[i]   <= nd_nxt[i];
        nn2_r[i]   <= nn_full[i][30:0];
        dd2_r[i]   <= dd_full[i][31:0];
        refl2_r[i] <= refl1_r[i];
      end
    end
  end

  // Stage 3: dot product and squared lengths; a non-positive dot becomes zero.
  logic               v3_r;
  logic [32:0]        dotp3_r;
  logic [31:0]        nn3_r;
  logic [33:0]        dd3_r;
  logic               dg3_r;
  logic [15:0]        refl3_r [3];
  logic signed [33:0] dot_sum;
  logic [31:0]        nn_sum;
  logic [33:0]        dd_sum;

  always_comb begin
    dot_sum = 34'(nd2_r[0]) + 34'(nd2_r[1]) + 34'(nd2_r[2]);
    nn_sum  = 32'(nn2_r[0]) + 32'(nn2_r[1]) + 32'(nn2_r[2]);
    dd_sum  = 34'(dd2_r[0]) + 34'(dd2_r[1]) + 34'(dd2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dotp3_r <= (dot_sum > 34'sd0) ? dot_sum[32:0] : 33'd0;
      nn3_r   <= nn_sum;
      dd3_r   <= dd_sum;
      dg3_r   <= (nn_sum == 32'd0) || (dd_sum == 34'd0);
      for (int i = 0; i < 3; i++) refl3_r[i] <= refl2_r[i];
    end
  end

  // Stage 4: partial products of dot^2 and nn * dd; dot and dd split at bit 17, nn at bit 16.
  logic        v4_r;
  logic [31:0] dhh4_r;
  logic [32:0] dhl4_r;
  logic [33:0] dll4_r;
  logic [32:0] nhh4_r;
  logic [32:0] nhl4_r;
  logic [32:0] nlh4_r;
  logic [32:0] nll4_r;
  logic        dg4_r;
  logic [15:0] refl4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dhh4_r <= 32'(dotp3_r[32:17]) * 32'(dotp3_r[32:17]);
      dhl4_r <= 33'(dotp3_r[32:17]) * 33'(dotp3_r[16:0]);
      dll4_r <= 34'(dotp3_r[16:0]) * 34'(dotp3_r[16:0]);
      nhh4_r <= 33'(nn3_r[31:16]) * 33'(dd3_r[33:17]);
      nhl4_r <= 33'(nn3_r[31:16]) * 33'(dd3_r[16:0]);
      nlh4_r <= 33'(nn3_r[15:0]) * 33'(dd3_r[33:17]);
      nll4_r <= 33'(nn3_r[15:0]) * 33'(dd3_r[16:0]);
      dg4_r  <= dg3_r;
      for (int i = 0; i < 3; i++) refl4_r[i] <= refl3_r[i];
    end
  end

  // Stage 5: sum the partial products into the cosine search start state.
  lds_cos_t        cs_r [NSTG+1];
  logic [R_W-1:0]  r_sum;
  logic [P_W-1:0]  p_sum;

  always_comb begin
    r_sum = (R_W'(dhh4_r) << 66) + (R_W'(dhl4_r) << 50) + (R_W'(dll4_r) << 32);
    p_sum = (P_W'(nhh4_r) << 33) + (P_W'(nhl4_r) << 16) + (P_W'(nlh4_r) << 17)
          + P_W'(nll4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r[0].vld <= 1'b0;
    end else if (adv) begin
      cs_r[0].vld <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0].x  <= '0;
      cs_r[0].y  <= '0;
      cs_r[0].c  <= '0;
      cs_r[0].p  <= p_sum;
      cs_r[0].r  <= r_sum;
      cs_r[0].dg <= dg4_r;
      cs_r[0].rr <= refl4_r[0];
      cs_r[0].rg <= refl4_r[1];
      cs_r[0].rb <= refl4_r[2];
    end
  end

  // Cosine search: stage k decides bit 16-k of c. With c^2*P and c*P carried along,
  // the trial (c + 2^b)^2 * P needs only shifts and one three-input add.
  for (genvar k = 0; k < NSTG; k++) begin : g_cos
    localparam int B = NSTG - 1 - k;
    logic [T_W-1:0] trial;
    logic           take;
    lds_cos_t       nxt;

    always_comb begin
      trial = T_W'(cs_r[k].x) + (T_W'(cs_r[k].y) << (B + 1)) + (T_W'(cs_r[k].p) << (2 * B));
      take  = trial <= T_W'(cs_r[k].r);
      nxt   = cs_r[k];
      if (take) begin
        nxt.x = trial[X_W-1:0];
        nxt.y = cs_r[k].y + (Y_W'(cs_r[k].p) << B);
        nxt.c = cs_r[k].c | (COS_BITS'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cs_r[k+1].vld <= 1'b0;
      end else if (adv) begin
        cs_r[k+1] <= nxt;
      end
    end
  end

  // Stage 6: reflectance times intensity per channel.
  logic                v6_r;
  logic [31:0]         ri6_r [3];
  logic [COS_BITS-1:0] c6_r;
  logic                dg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= cs_r[NSTG].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ri6_r[0] <= 32'(cs_r[NSTG].rr) * 32'(inten_r[0]);
      ri6_r[1] <= 32'(cs_r[NSTG].rg) * 32'(inten_r[1]);
      ri6_r[2] <= 32'(cs_r[NSTG].rb) * 32'(inten_r[2]);
      c6_r     <= cs_r[NSTG].c;
      dg6_r    <= cs_r[NSTG].dg;
    end
  end

  // Stage 7: scale by the cosine, truncate, saturate; output register.
  logic [48:0] prod [3];
  logic [15:0] shade_nxt [3];
  logic [15:0] shade_r [3];
  logic        dg7_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = 49'(ri6_r[i]) * 49'(c6_r);
      if (dg6_r) begin
        shade_nxt[i] = 16'd0;
      end else if (prod[i][48]) begin
        shade_nxt[i] = 16'hFFFF;
      end else begin
        shade_nxt[i] = prod[i][47:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) shade_r[i] <= shade_nxt[i];
      dg7_r <= dg6_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_shade_r    = shade_r[0];
  assign out_shade_g    = shade_r[1];
  assign out_shade_b    = shade_r[2];
  assign out_degenerate = dg7_r;

  // A degenerate result always carries zero shades.
  a_dg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> (out_shade_r == 16'd0) && (out_shade_g == 16'd0)
                                    && (out_shade_b == 16'd0))
    else $error("degenerate result with nonzero shade");

  // The cosine of a well-formed item never exceeds one.
  a_cos_max: assert property (@(posedge clk) disable iff (!rst_n)
    cs_r[NSTG].vld && !cs_r[NSTG].dg |-> cs_r[NSTG].c <= COS_ONE)
    else $error("cosine above one");

  // A surface facing away from the light ends with a zero cosine.
  a_back_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cs_r[NSTG].vld && !cs_r[NSTG].dg && (cs_r[NSTG].r == '0) |-> cs_r[NSTG].c == '0)
    else $error("nonzero cosine for back-facing surface");

  // An accepted transfer enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted transfer lost at entry");

endmodule

// File: dv/lambert_diffuse_shade_unit_test.sv
// Self-checking testbench for lambert_diffuse_shade_unit.
// Depends on lds_pkg and the unit; a scoreboard class predicts each shade result.
`timescale 1ns / 100ps

module lambert_diffuse_shade_unit_test;
  import lds_pkg::*;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int QUIET_LIMIT = 4000;   // cycles without any transfer
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [15:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        kr, kg, kb;
  } surf_pt_t;

  typedef struct {
    logic [15:0] r, g, b;
    logic        dg;
  } shade_t;

  // Scoreboard: holds a copy of the light registers and the shades still owed.
  class shade_board;
    logic signed [15:0] light[3];
    logic [15:0]        inten[3];
    shade_t             owed[$];
    int                 errors;
    int                 checked;
    int                 degen_seen;

    function void clear();
      light = '{16'sd0, 16'sd0, 16'sd0};
      inten = '{16'd256, 16'd256, 16'd256};
      owed.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx <= REG_LIGHT_Z) light[idx] = val;
      else if (idx <= REG_INTENSITY_B) inten[idx - REG_INTENSITY_R] = val;
    endfunction

    // floor(65536 * cos) found bit by bit: largest c with c^2*nn*dd <= dot^2*2^32.
    function logic [16:0] cos_q16(longint dot, longint unsigned nn, longint unsigned dd);
      logic [127:0] bound, trial_sq;
      logic [16:0]  c, t;
      bound = ({64'd0, dot} * {64'd0, dot}) << 32;
      c = 0;
      for (int b = 16; b >= 0; b--) begin
        t = c | (17'd1 << b);
        if (t > COS_ONE) continue;
        trial_sq = 128'(t) * 128'(t) * 128'(nn) * 128'(dd);
        if (trial_sq <= bound) c = t;
      end
      return c;
    endfunction

    function void note_input(surf_pt_t s);
      longint          d[3], n[3];
      longint          dot;
      longint unsigned nn, dd, v;
      logic [16:0]     c;
      logic [15:0]     k[3];
      shade_t          e;
      d[0] = longint'(light[0]) - longint'(s.px);
      d[1] = longint'(light[1]) - longint'(s.py);
      d[2] = longint'(light[2]) - longint'(s.pz);
      n[0] = s.nx; n[1] = s.ny; n[2] = s.nz;
      k = '{s.kr, s.kg, s.kb};
      dot = 0; nn = 0; dd = 0;
      for (int i = 0; i < 3; i++) begin
        dot += n[i] * d[i];
        nn += n[i] * n[i];
        dd += d[i] * d[i];
      end
      e = '{r: 0, g: 0, b: 0, dg: 0};
      if (nn == 0 || dd == 0) begin
        e.dg = 1;
      end else begin
        c = (dot > 0) ? cos_q16(dot, nn, dd) : 17'd0;
        for (int i = 0; i < 3; i++) begin
          v = (64'(k[i]) * 64'(inten[i]) * 64'(c)) >> 32;
          if (v > 64'hFFFF) v = 64'hFFFF;
          if (i == 0) e.r = v[15:0];
          else if (i == 1) e.g = v[15:0];
          else e.b = v[15:0];
        end
      end
      owed.push_back(e);
    endfunction

    function void check_result(shade_t a);
      shade_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result r=%h g=%h b=%h dg=%b", $time, a.r, a.g, a.b, a.dg);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (a.dg) degen_seen++;
      if (a.r !== e.r) begin
        $display("%0t: shade_r expected %h actual %h", $time, e.r, a.r); errors++;
      end
      if (a.g !== e.g) begin
        $display("%0t: shade_g expected %h actual %h", $time, e.g, a.g); errors++;
      end
      if (a.b !== e.b) begin
        $display("%0t: shade_b expected %h actual %h", $time, e.b, a.b); errors++;
      end
      if (a.dg !== e.dg) begin
        $display("%0t: degenerate expected %b actual %b", $time, e.dg, a.dg); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [15:0] in_point_x, in_point_y, in_point_z;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic [15:0] in_refl_r, in_refl_g, in_refl_b;
  logic out_valid, out_stall;
  logic [15:0] out_shade_r, out_shade_g, out_shade_b;
  logic out_degenerate;

  lambert_diffuse_shade_unit uut (.*);

  shade_board board = new();
  int quiet_cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure: a random mode is picked each time the phase counter wraps, so
  // that some stretches never stall, some stall at random and some stall in long runs.
  always @(negedge clk) begin
    stall_phase <= (stall_phase == 149) ? 0 : stall_phase + 1;
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= (stall_phase % 16) < 11;
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  // Result monitor and the watchdog that ends a hung run. The watchdog counts cycles
  // with no input, result or configuration transfer while a result is owed or an input waits.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result('{r: out_shade_r, g: out_shade_g, b: out_shade_b,
                             dg: out_degenerate});
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (board.owed.size() != 0 || in_valid)
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, board.owed.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one surface point; the sender works in bursts with random gaps between.
  task automatic send_point(surf_pt_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    {in_point_x, in_point_y, in_point_z} = {s.px, s.py, s.pz};
    {in_normal_x, in_normal_y, in_normal_z} = {s.nx, s.ny, s.nz};
    {in_refl_r, in_refl_g, in_refl_b} = {s.kr, s.kg, s.kb};
    do @(posedge clk); while (in_stall);
    board.note_input(s);
    sent++;
  endtask

  // Hold the sender off until every owed result has come, then let the pipe drain.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    wait (board.owed.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random point: half lit geometry with random content, plus the degenerate
  // shapes and fully random fields.
  function automatic surf_pt_t rand_point();
    surf_pt_t s;
    int kind;
    kind = $urandom_range(0, 19);
    s.px = pick16(); s.py = pick16(); s.pz = pick16();
    s.nx = pick16(); s.ny = pick16(); s.nz = pick16();
    s.kr = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    s.kg = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    s.kb = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    if (kind < 10) begin
      // Normal roughly along the light direction, so the cosine is large.
      s.px = board.light[0] - 16'($signed($urandom_range(0, 1023)) - 512);
      s.py = board.light[1] - 16'($signed($urandom_range(0, 1023)) - 512);
      s.pz = board.light[2] - 16'($signed($urandom_range(0, 1023)) - 512);
      s.nx = (board.light[0] - s.px) + 16'($signed($urandom_range(0, 63)) - 32);
      s.ny = (board.light[1] - s.py) + 16'($signed($urandom_range(0, 63)) - 32);
      s.nz = (board.light[2] - s.pz) + 16'($signed($urandom_range(0, 63)) - 32);
    end else if (kind == 10) begin
      s.nx = 0; s.ny = 0; s.nz = 0;
    end else if (kind == 11) begin
      s.px = board.light[0]; s.py = board.light[1]; s.pz = board.light[2];
    end
    return s;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_point(rand_point());
  endtask

  task automatic run_directed();
    surf_pt_t s;
    // Normal pointing straight at the light: cosine of one.
    s = '{px: 0, py: 0, pz: -16'sd256, nx: 0, ny: 0, nz: 16'sd256,
          kr: 16'hFFFF, kg: 16'h8000, kb: 16'h0000};
    send_point(s);
    // Zero normal.
    s.nz = 0;
    send_point(s);
    // Point sitting on the light.
    s = '{px: 0, py: 0, pz: 0, nx: 16'sd1, ny: 0, nz: 0, kr: 16'hFFFF, kg: 16'hFFFF,
          kb: 16'hFFFF};
    send_point(s);
    // Surface facing away from the light, and exactly edge-on.
    s = '{px: 0, py: 0, pz: -16'sd256, nx: 0, ny: 0, nz: -16'sd256, kr: 16'hFFFF,
          kg: 16'hFFFF, kb: 16'hFFFF};
    send_point(s);
    s.nz = 0; s.nx = 16'sd256;
    send_point(s);
    // Field extremes.
    s = '{px: 16'sh8000, py: 16'sh8000, pz: 16'sh8000, nx: 16'sh7FFF, ny: 16'sh7FFF,
          nz: 16'sh7FFF, kr: 16'hFFFF, kg: 16'hFFFF, kb: 16'hFFFF};
    send_point(s);
    s = '{px: 16'sh7FFF, py: 16'sh7FFF, pz: 16'sh7FFF, nx: 16'sh8000, ny: 16'sh8000,
          nz: 16'sh8000, kr: 16'h0001, kg: 16'h0000, kb: 16'hFFFF};
    send_point(s);
    s = '{px: 16'sh7FFF, py: 16'sh8000, pz: 16'sh0001, nx: 16'sh8000, ny: 16'sh7FFF,
          nz: 16'shFFFF, kr: 16'h5555, kg: 16'hAAAA, kb: 16'hFFFF};
    send_point(s);
    s = '{px: 0, py: 0, pz: 0, nx: 16'sh8000, ny: 0, nz: 0, kr: 16'hFFFF,
          kg: 16'hFFFF, kb: 16'hFFFF};
    send_point(s);
    s.nx = 16'sh7FFF;
    send_point(s);
  endtask

  // One light setting: light position and intensities, plus a spare index.
  task automatic set_light(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                           logic [15:0] ir, logic [15:0] ig, logic [15:0] ib);
    write_cfg(REG_LIGHT_X, lx);
    write_cfg(REG_LIGHT_Y, ly);
    write_cfg(REG_LIGHT_Z, lz);
    write_cfg(REG_INTENSITY_R, ir);
    write_cfg(REG_INTENSITY_G, ig);
    write_cfg(REG_INTENSITY_B, ib);
    write_cfg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    {in_point_x, in_point_y, in_point_z} = '0;
    {in_normal_x, in_normal_y, in_normal_z} = '0;
    {in_refl_r, in_refl_g, in_refl_b} = '0;
    board.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values first, then directed points under a full-scale light.
    run_directed();
    drain();
    set_light(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_directed();
    run_random(200);
    drain();
    set_light(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF);
    run_random(200);
    drain();
    set_light(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0100);
    run_random(200);
    for (int k = 0; k < 3; k++) begin
      drain();
      set_light(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      run_random(200);
    end
    drain();

    $display("Sent %0d surface points across seven light settings; %0d shades checked,",
             sent, board.checked);
    $display("%0d of them degenerate.", board.degen_seen);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
